// ===== design/cmig_pkg.sv =====
`default_nettype none
package cmig_pkg;

   // Fixed field widths
   localparam int CFG_W       = 11;
   localparam int CMP_W       = CFG_W + 1;
   localparam int IDX_W       = 21;
   localparam int REG_W       = 2;
   localparam int CSR_ADDR_W  = 2;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 64;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SECTOR_COUNT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STACK_COUNT  = 2'd1;

   // Region codes
   localparam logic [REG_W-1:0] REGION_BASE = 2'd0;
   localparam logic [REG_W-1:0] REGION_SIDE = 2'd1;
   localparam logic [REG_W-1:0] REGION_TIP  = 2'd2;

   // Walk phase, one-hot
   typedef enum logic [2:0] {
      PH_BASE = 3'b001,
      PH_SIDE = 3'b010,
      PH_TIP  = 3'b100
   } phase_type;

   // One triangle of the index list
   typedef struct packed {
      logic [IDX_W-1:0] first_index;
      logic [IDX_W-1:0] second_index;
      logic [IDX_W-1:0] third_index;
      logic [REG_W-1:0] region;
      logic             last_triangle;
   } triangle_type;

endpackage
`default_nettype wire

// ===== design/cmig_csr.sv =====
`default_nettype none
module cmig_csr #(
   parameter int MAX_SECTORS = 1024,
   parameter int MAX_STACKS  = 1024,
   localparam int SEC_LIM = (MAX_SECTORS < 2047) ? MAX_SECTORS : 2047,
   localparam int STK_LIM = (MAX_STACKS < 2047) ? MAX_STACKS : 2047,
   localparam int SEC_EW  = $clog2(SEC_LIM + 1),
   localparam int STK_EW  = $clog2(STK_LIM + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [cmig_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [cmig_pkg::CFG_W-1:0]       csr_wdata,
   output logic      [SEC_EW-1:0]                sec_count,
   output logic      [STK_EW-1:0]                stk_count,
   output logic                                  wr_hit
);
   import cmig_pkg::*;

   localparam int SEC_RST = (SEC_LIM < 8) ? SEC_LIM : 8;
   localparam int STK_RST = (STK_LIM < 4) ? STK_LIM : 4;

   logic [SEC_EW-1:0] sec_ff, sec_in, sec_clamp;
   logic [STK_EW-1:0] stk_ff, stk_in, stk_clamp;

   // Saturate the written value into the usable range once, at write time
   always_comb begin
      if (csr_wdata < CFG_W'(3)) begin
         sec_clamp = SEC_EW'(3);
      end else if (csr_wdata > CFG_W'(SEC_LIM)) begin
         sec_clamp = SEC_EW'(SEC_LIM);
      end else begin
         sec_clamp = SEC_EW'(csr_wdata);
      end
      if (csr_wdata < CFG_W'(1)) begin
         stk_clamp = STK_EW'(1);
      end else if (csr_wdata > CFG_W'(STK_LIM)) begin
         stk_clamp = STK_EW'(STK_LIM);
      end else begin
         stk_clamp = STK_EW'(csr_wdata);
      end
   end

   // Register decode; any hit restarts the walk
   always_comb begin
      sec_in = sec_ff;
      stk_in = stk_ff;
      wr_hit = 1'b0;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SECTOR_COUNT: begin
               sec_in = sec_clamp;
               wr_hit = 1'b1;
            end
            CSR_STACK_COUNT: begin
               stk_in = stk_clamp;
               wr_hit = 1'b1;
            end
            default: begin
               wr_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff <= SEC_EW'(SEC_RST);
         stk_ff <= STK_EW'(STK_RST);
      end else begin
         sec_ff <= sec_in;
         stk_ff <= stk_in;
      end
   end

   assign sec_count = sec_ff;
   assign stk_count = stk_ff;

endmodule
`default_nettype wire

// ===== design/cmig_walk.sv =====
`default_nettype none
module cmig_walk #(
   parameter int MAX_SECTORS = 1024,
   parameter int MAX_STACKS  = 1024,
   localparam int SEC_LIM = (MAX_SECTORS < 2047) ? MAX_SECTORS : 2047,
   localparam int STK_LIM = (MAX_STACKS < 2047) ? MAX_STACKS : 2047,
   localparam int SEC_EW  = $clog2(SEC_LIM + 1),
   localparam int STK_EW  = $clog2(STK_LIM + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   restart,
   input  wire logic                   clear,
   input  wire logic [SEC_EW-1:0]      sec_count,
   input  wire logic [STK_EW-1:0]      stk_count,
   output cmig_pkg::triangle_type      triangle
);
   import cmig_pkg::*;

   localparam int SEC_W  = $clog2(SEC_LIM);
   localparam int RING_W = (STK_LIM > 2) ? $clog2(STK_LIM - 1) : 1;

   phase_type         phase_ff, phase_in, cur_phase;
   logic [SEC_W-1:0]  sec_cnt_ff, sec_cnt_in, cur_s, nx;
   logic [RING_W-1:0] ring_ff, ring_in, cur_ring;
   logic              half_ff, half_in, cur_half;
   logic [IDX_W-1:0]  base_ff, base_in, cur_base;
   logic              start, end_sector;
   logic [CMP_W-1:0]  s_plus;
   logic [IDX_W-1:0]  up_base, tip_index;
   logic [SEC_EW+STK_EW-1:0] tip_prod;

   // Tip vertex index: stacks * sectors + 1
   assign tip_prod  = sec_count * stk_count;
   assign tip_index = IDX_W'(tip_prod) + IDX_W'(1);

   // Current position, forced to the first base triangle on restart or a bad phase
   always_comb begin
      start = restart ||
              !(phase_ff == PH_BASE || phase_ff == PH_SIDE || phase_ff == PH_TIP);
      if (start) begin
         cur_phase = PH_BASE;
         cur_s     = '0;
         cur_ring  = '0;
         cur_half  = 1'b0;
         cur_base  = IDX_W'(1);
      end else begin
         cur_phase = phase_ff;
         cur_s     = sec_cnt_ff;
         cur_ring  = ring_ff;
         cur_half  = half_ff;
         cur_base  = base_ff;
      end
      s_plus     = CMP_W'(cur_s) + CMP_W'(1);
      end_sector = s_plus >= CMP_W'(sec_count);
      nx         = end_sector ? '0 : SEC_W'(s_plus);
      up_base    = cur_base + IDX_W'(sec_count);
   end

   // Triangle for the current position and the next position
   always_comb begin
      triangle   = '0;
      phase_in   = cur_phase;
      sec_cnt_in = cur_s;
      ring_in    = cur_ring;
      half_in    = cur_half;
      base_in    = cur_base;
      unique case (cur_phase)
         PH_SIDE: begin
            triangle.region = REGION_SIDE;
            if (!cur_half) begin
               triangle.first_index  = cur_base + IDX_W'(cur_s);
               triangle.second_index = up_base + IDX_W'(cur_s);
               triangle.third_index  = cur_base + IDX_W'(nx);
               half_in = 1'b1;
            end else begin
               triangle.first_index  = up_base + IDX_W'(cur_s);
               triangle.second_index = up_base + IDX_W'(nx);
               triangle.third_index  = cur_base + IDX_W'(nx);
               half_in = 1'b0;
               if (end_sector) begin
                  sec_cnt_in = '0;
                  base_in    = up_base;
                  if (CMP_W'(cur_ring) + CMP_W'(2) >= CMP_W'(stk_count)) begin
                     phase_in = PH_TIP;
                  end else begin
                     ring_in = cur_ring + RING_W'(1);
                  end
               end else begin
                  sec_cnt_in = SEC_W'(s_plus);
               end
            end
         end
         PH_TIP: begin
            triangle.region       = REGION_TIP;
            triangle.first_index  = tip_index;
            triangle.second_index = cur_base + IDX_W'(nx);
            triangle.third_index  = cur_base + IDX_W'(cur_s);
            if (end_sector) begin
               triangle.last_triangle = 1'b1;
               phase_in   = PH_BASE;
               sec_cnt_in = '0;
               ring_in    = '0;
               half_in    = 1'b0;
               base_in    = IDX_W'(1);
            end else begin
               sec_cnt_in = SEC_W'(s_plus);
            end
         end
         default: begin
            // base fan around vertex 0
            triangle.region       = REGION_BASE;
            triangle.first_index  = '0;
            triangle.second_index = IDX_W'(s_plus);
            triangle.third_index  = IDX_W'(nx) + IDX_W'(1);
            if (end_sector) begin
               sec_cnt_in = '0;
               ring_in    = '0;
               base_in    = IDX_W'(1);
               phase_in   = (stk_count == STK_EW'(1)) ? PH_TIP : PH_SIDE;
            end else begin
               sec_cnt_in = SEC_W'(s_plus);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff   <= PH_BASE;
         sec_cnt_ff <= '0;
         ring_ff    <= '0;
         half_ff    <= 1'b0;
         base_ff    <= IDX_W'(1);
      end else if (advance) begin
         phase_ff   <= phase_in;
         sec_cnt_ff <= sec_cnt_in;
         ring_ff    <= ring_in;
         half_ff    <= half_in;
         base_ff    <= base_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/cone_mesh_index_generator.sv =====
// Cone mesh triangle index generator.
// An accepted request's triangle appears on the rsp channel in the next cycle.
// Throughput: one triangle per cycle while rsp_tready stays high; the longest path is the tip index
//   multiply (sectors * stacks) feeding the output register.
// Reset (synchronous): no result pending, walk at the first base triangle,
//   sector count 8, stack count 4.
`default_nettype none
module cone_mesh_index_generator #(
   parameter int MAX_SECTORS = 1024,
   parameter int MAX_STACKS  = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [cmig_pkg::REQ_TDATA_W-1:0]  req_tdata,   // [0] restart
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [20:0] first_index, [41:21] second_index, [62:42] third_index
   output logic      [cmig_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic      [cmig_pkg::REG_W-1:0]        rsp_tuser,   // [1:0] region
   output logic                                   rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic [cmig_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [cmig_pkg::CFG_W-1:0]        csr_wdata
);
   import cmig_pkg::*;

   localparam int SEC_LIM = (MAX_SECTORS < 2047) ? MAX_SECTORS : 2047;
   localparam int STK_LIM = (MAX_STACKS < 2047) ? MAX_STACKS : 2047;
   localparam int SEC_EW  = $clog2(SEC_LIM + 1);
   localparam int STK_EW  = $clog2(STK_LIM + 1);

   logic [SEC_EW-1:0] sec_count;
   logic [STK_EW-1:0] stk_count;
   logic              wr_hit;
   logic              accept;
   logic              rsp_valid_ff, rsp_valid_in;
   triangle_type      triangle;
   triangle_type      tri_ff;

   cmig_csr #(
      .MAX_SECTORS (MAX_SECTORS),
      .MAX_STACKS  (MAX_STACKS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .sec_count (sec_count),
      .stk_count (stk_count),
      .wr_hit    (wr_hit)
   );

   cmig_walk #(
      .MAX_SECTORS (MAX_SECTORS),
      .MAX_STACKS  (MAX_STACKS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .advance   (accept),
      .restart   (req_tdata[0]),
      .clear     (wr_hit),
      .sec_count (sec_count),
      .stk_count (stk_count),
      .triangle  (triangle)
   );

   // Output register: take a new request whenever the slot is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tri_ff <= triangle;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, tri_ff.third_index, tri_ff.second_index, tri_ff.first_index};
   assign rsp_tuser  = tri_ff.region;
   assign rsp_tlast  = tri_ff.last_triangle;

   // Only a tip fan triangle closes the mesh
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == REGION_TIP)
      else $error("last triangle outside tip fan");

   // Base fan triangles always start at the center vertex
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == REGION_BASE |-> rsp_tdata[IDX_W-1:0] == '0)
      else $error("base triangle without center vertex");

   // A restart request yields the first base triangle
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tdata[0] && !csr_we |=>
         rsp_tvalid && rsp_tuser == REGION_BASE && !rsp_tlast &&
         rsp_tdata[2*IDX_W-1:IDX_W] == IDX_W'(1))
      else $error("restart did not return to first base triangle");

endmodule
`default_nettype wire

// ===== test/cone_mesh_index_generator_tb.sv =====
`timescale 1ns / 100ps

module cone_mesh_index_generator_tb;
   import cmig_pkg::*;

   localparam int SECTOR_CAP     = 1024;
   localparam int STACK_CAP      = 1024;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 14;
   localparam int MAX_REPORTS    = 10;

   // register indexes that decode to nothing
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_HI = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [REG_W-1:0]       rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CFG_W-1:0]       csr_wdata;

   // receiver controls, set by the sender side, then hold-off and stall counters
   bit rsp_hold;
   bit rsp_steady;
   int holds_done;
   int stall_cycles;

   // Mesh walk predictor and triangle checker
   class mesh_scoreboard;
      logic [CFG_W-1:0] sector_reg;
      logic [CFG_W-1:0] stack_reg;
      phase_type        walk_phase;
      logic [9:0]       ring_count;
      logic [9:0]       sector_pos;
      logic             quad_upper;
      logic [IDX_W-1:0] lower_base;
      triangle_type     expected_triangles[$];
      int               mismatches;
      int               triangles_checked;
      int               region_hits[3];
      int               list_ends;
      int               restarts;

      function new();
         sector_reg = CFG_W'(8);
         stack_reg  = CFG_W'(4);
         walk_home();
      endfunction

      function void walk_home();
         walk_phase = PH_BASE;
         ring_count = '0;
         sector_pos = '0;
         quad_upper = 1'b0;
         lower_base = IDX_W'(1);
      endfunction

      function int clamp_count(int v, int lo, int hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      // any write to a real register rewinds the walk
      function void write_register(logic [CSR_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
         case (addr)
            CSR_SECTOR_COUNT: begin
               sector_reg = data;
               walk_home();
            end
            CSR_STACK_COUNT: begin
               stack_reg = data;
               walk_home();
            end
            default: ;
         endcase
      endfunction

      // next triangle of the index list for one accepted request
      function void predict_triangle(bit restart);
         int           sec;
         int           stk;
         int           s;
         int           nx;
         int           up;
         bit           end_sector;
         triangle_type t;
         sec = clamp_count(int'(sector_reg), 3, SECTOR_CAP);
         stk = clamp_count(int'(stack_reg), 1, STACK_CAP);
         if (restart) begin
            walk_home();
            restarts++;
         end
         s          = int'(sector_pos);
         end_sector = (s + 1 >= sec);
         nx         = end_sector ? 0 : s + 1;
         t          = '0;
         case (walk_phase)
            PH_BASE: begin
               t.region       = REGION_BASE;
               t.first_index  = '0;
               t.second_index = IDX_W'(s + 1);
               t.third_index  = IDX_W'(nx + 1);
               if (end_sector) begin
                  sector_pos = '0;
                  ring_count = '0;
                  lower_base = IDX_W'(1);
                  if (stk == 1) walk_phase = PH_TIP;
                  else walk_phase = PH_SIDE;
               end else begin
                  sector_pos = 10'(s + 1);
               end
            end
            PH_SIDE: begin
               up       = int'(lower_base) + sec;
               t.region = REGION_SIDE;
               if (!quad_upper) begin
                  t.first_index  = IDX_W'(int'(lower_base) + s);
                  t.second_index = IDX_W'(up + s);
                  t.third_index  = IDX_W'(int'(lower_base) + nx);
                  quad_upper     = 1'b1;
               end else begin
                  t.first_index  = IDX_W'(up + s);
                  t.second_index = IDX_W'(up + nx);
                  t.third_index  = IDX_W'(int'(lower_base) + nx);
                  quad_upper     = 1'b0;
                  if (end_sector) begin
                     sector_pos = '0;
                     lower_base = IDX_W'(int'(lower_base) + sec);
                     if (int'(ring_count) + 2 >= stk) walk_phase = PH_TIP;
                     else ring_count = ring_count + 10'd1;
                  end else begin
                     sector_pos = 10'(s + 1);
                  end
               end
            end
            default: begin
               t.region       = REGION_TIP;
               t.first_index  = IDX_W'(stk * sec + 1);
               t.second_index = IDX_W'(int'(lower_base) + nx);
               t.third_index  = IDX_W'(int'(lower_base) + s);
               if (end_sector) begin
                  t.last_triangle = 1'b1;
                  walk_home();
               end else begin
                  sector_pos = 10'(s + 1);
               end
            end
         endcase
         expected_triangles.insert(expected_triangles.size(), t);
      endfunction

      function void check_triangle(triangle_type got);
         triangle_type exp_t;
         if (expected_triangles.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR %0t: triangle %0d %0d %0d with nothing expected",
                        $realtime, got.first_index, got.second_index, got.third_index);
            return;
         end
         exp_t = expected_triangles.pop_front();
         triangles_checked++;
         if (got != exp_t) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("ERROR %0t: triangle %0d mismatch", $realtime, triangles_checked);
               $display("   expected idx %0d %0d %0d region %0d last %0d",
                        exp_t.first_index, exp_t.second_index, exp_t.third_index,
                        exp_t.region, exp_t.last_triangle);
               $display("   actual   idx %0d %0d %0d region %0d last %0d",
                        got.first_index, got.second_index, got.third_index,
                        got.region, got.last_triangle);
            end
         end
         if (exp_t.region <= REGION_TIP) region_hits[exp_t.region]++;
         if (exp_t.last_triangle) list_ends++;
      endfunction
   endclass

   mesh_scoreboard mesh_check;

   cone_mesh_index_generator #(
      .MAX_SECTORS(SECTOR_CAP),
      .MAX_STACKS (STACK_CAP)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Monitor: predict on accepted requests, check accepted triangles, watchdog
   always @(posedge clock) begin : monitor
      triangle_type got;
      if (!reset) begin
         if (csr_we) mesh_check.write_register(csr_addr, csr_wdata);
         if (req_tvalid && req_tready) mesh_check.predict_triangle(req_tdata[0]);
         if (rsp_tvalid && rsp_tready) begin
            got.first_index   = rsp_tdata[IDX_W-1:0];
            got.second_index  = rsp_tdata[2*IDX_W-1:IDX_W];
            got.third_index   = rsp_tdata[3*IDX_W-1:2*IDX_W];
            got.region        = rsp_tuser;
            got.last_triangle = rsp_tlast;
            mesh_check.check_triangle(got);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", stall_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Receiver: random ready pattern, plus one long hold-off on demand
   initial begin : receiver
      int run;
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold = 1'b0;
            holds_done++;
         end
         rsp_tready <= 1'b1;
         run = rsp_steady ? 8 : $urandom_range(1, 12);
         repeat (run) @(negedge clock);
         gap = rsp_steady ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // one request, then an optional gap; tvalid stays up between back-to-back requests
   task automatic offer(input bit restart, input bit gaps_on);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-1){1'b0}}, restart};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      gap = (gaps_on && !rsp_hold) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (mesh_check.expected_triangles.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Stimulus
   initial begin : stimulus
      logic [CFG_W-1:0] sec_val;
      logic [CFG_W-1:0] stk_val;
      int               count;
      bit               steady;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      reset      = 1'b1;
      rsp_hold   = 1'b0;
      rsp_steady = 1'b0;
      mesh_check = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset sizes, with a restart in the middle of the base fan
      offer(1'b0, 1'b1);
      offer(1'b0, 1'b1);
      offer(1'b0, 1'b1);
      offer(1'b1, 1'b1);
      offer(1'b0, 1'b1);

      // sizes below range saturate to 3 sectors, 1 stack: no side, list wraps
      wait_drained();
      write_csr(CSR_SECTOR_COUNT, CFG_W'(1));
      write_csr(CSR_STACK_COUNT, CFG_W'(0));
      repeat (7) offer(1'b0, 1'b1);

      // two stacks: whole list, unused indexes written mid-walk must not rewind
      wait_drained();
      write_csr(CSR_SECTOR_COUNT, CFG_W'(3));
      write_csr(CSR_STACK_COUNT, CFG_W'(2));
      repeat (6) offer(1'b0, 1'b1);
      wait_drained();
      write_csr(CSR_UNUSED_LO, '1);
      write_csr(CSR_UNUSED_HI, '0);
      repeat (6) offer(1'b0, 1'b1);

      // random phases over many sizes
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            2: begin
               sec_val = '1;
               stk_val = '1;
               count   = 40;
            end
            5: begin
               sec_val = CFG_W'(SECTOR_CAP);
               stk_val = CFG_W'(1);
               count   = 40;
            end
            8: begin
               sec_val = CFG_W'(3);
               stk_val = CFG_W'(STACK_CAP);
               count   = 70;
            end
            10: begin
               sec_val = CFG_W'($urandom_range(900, SECTOR_CAP));
               stk_val = CFG_W'(2);
               count   = 30;
            end
            default: begin
               sec_val = CFG_W'($urandom_range(0, 10));
               stk_val = CFG_W'($urandom_range(0, 6));
               count   = 60;
            end
         endcase
         wait_drained();
         if (p % 5 == 4) begin
            write_csr(CSR_STACK_COUNT, stk_val);
         end else if ($urandom_range(0, 1) == 1) begin
            write_csr(CSR_SECTOR_COUNT, sec_val);
            write_csr(CSR_STACK_COUNT, stk_val);
         end else begin
            write_csr(CSR_STACK_COUNT, stk_val);
            write_csr(CSR_SECTOR_COUNT, sec_val);
         end
         steady     = (p % 4 == 3);
         rsp_steady = steady;
         for (int i = 0; i < count; i++) begin
            // long receiver hold-off while requests keep coming
            if ((p == 1 || p == 6) && i == 8) rsp_hold = 1'b1;
            // full pause, then a same-value rewrite that rewinds the walk
            if (p == 4 && i == count / 2) begin
               wait_drained();
               write_csr(CSR_SECTOR_COUNT, mesh_check.sector_reg);
            end
            offer($urandom_range(0, 39) == 0, !steady);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Checked %0d triangles: base %0d, side %0d, tip %0d; %0d full lists",
               mesh_check.triangles_checked, mesh_check.region_hits[0],
               mesh_check.region_hits[1], mesh_check.region_hits[2], mesh_check.list_ends);
      $display("%0d restarts, %0d size settings, %0d receiver hold-offs, %0d mismatches",
               mesh_check.restarts, RANDOM_PHASES + 3, holds_done, mesh_check.mismatches);
      if (mesh_check.mismatches == 0 && mesh_check.expected_triangles.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
